// ----- rtl/realtime_command_rx_front_end_core_macros.svh -----
// Assertion macros used by the back part of the receive front end RTL
`ifndef REALTIME_COMMAND_RX_FRONT_END_CORE_MACROS_SVH
`define REALTIME_COMMAND_RX_FRONT_END_CORE_MACROS_SVH

// same-cycle implication, disabled in reset
`define RCRX_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rcrx assertion failed");

// next-cycle implication, disabled in reset
`define RCRX_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rcrx assertion failed");

`endif

// ----- rtl/rcrx_pkg.sv -----
// Types, codes and constants of the realtime command receive front end
package rcrx_pkg;

    localparam int QUEUE_DEPTH_DEFAULT = 4;

    localparam logic [7:0] CAPACITY_RESET      = 8'd127;
    localparam logic [7:0] BYTE_STATUS         = 8'h3F;
    localparam logic [7:0] BYTE_HOLD           = 8'h21;
    localparam logic [7:0] BYTE_RESUME         = 8'h7E;
    localparam logic [7:0] BYTE_RESET          = 8'h18;
    localparam logic [7:0] BYTE_JOG_CANCEL     = 8'h85;
    localparam logic [7:0] BYTE_COOLANT_TOGGLE = 8'h9E;
    localparam logic [7:0] BYTE_LF             = 8'h0A;
    localparam logic [7:0] BYTE_CR             = 8'h0D;
    localparam logic [7:0] LINE_COUNT_MAX      = 8'hFF;

    typedef enum logic [3:0] {
        ACT_NONE      = 4'd0,
        ACT_STORED    = 4'd1,
        ACT_LINE_END  = 4'd2,
        ACT_STATUS    = 4'd3,
        ACT_HOLD      = 4'd4,
        ACT_RESUME    = 4'd5,
        ACT_RESET     = 4'd6,
        ACT_JOG       = 4'd7,
        ACT_TOGGLE    = 4'd8,
        ACT_OVERFLOW  = 4'd9
    } t_action;

    typedef enum logic [3:0] {
        K_IGNORE,
        K_STATUS,
        K_HOLD,
        K_RESUME,
        K_RESET,
        K_JOG,
        K_TOGGLE,
        K_LINE_END,
        K_ORDINARY,
        K_BLOCK
    } t_kind;

    typedef struct packed {
        logic       op;
        logic [7:0] rx_byte;
        logic       block_coolant_on;
        logic       block_coolant_off;
    } t_in_item;

    typedef struct packed {
        logic [3:0] action;
        logic [7:0] data_byte;
        logic [7:0] line_length;
        logic       hold_active;
        logic       coolant_on;
        logic       coolant_suspended;
        logic [7:0] unacked_bytes;
        logic       halted;
    } t_out_item;

    // classified command passed from front to back
    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
        logic       cool_on;
        logic       cool_off;
    } t_cmd;

endpackage

// ----- rtl/rcrx_front.sv -----
// Front part: accepts items and classifies them into commands
module rcrx_front (
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  rcrx_pkg::t_in_item i_in_data,
    input  logic              i_q_ready,
    output logic              o_q_valid,
    output rcrx_pkg::t_cmd    o_q_cmd
);
    import rcrx_pkg::*;

    t_kind w_kind;

    assign o_in_ready = i_q_ready;
    assign o_q_valid  = i_in_valid;

    always_comb begin
        if (i_in_data.op) begin
            w_kind = K_BLOCK;
        end else begin
            case (i_in_data.rx_byte)
                BYTE_RESET:          w_kind = K_RESET;
                BYTE_STATUS:         w_kind = K_STATUS;
                BYTE_HOLD:           w_kind = K_HOLD;
                BYTE_RESUME:         w_kind = K_RESUME;
                BYTE_JOG_CANCEL:     w_kind = K_JOG;
                BYTE_COOLANT_TOGGLE: w_kind = K_TOGGLE;
                BYTE_LF, BYTE_CR:    w_kind = K_LINE_END;
                default: begin
                    // remaining high bytes are dropped
                    if (i_in_data.rx_byte[7]) w_kind = K_IGNORE;
                    else                      w_kind = K_ORDINARY;
                end
            endcase
        end
    end

    always_comb begin
        o_q_cmd.kind     = w_kind;
        o_q_cmd.data     = i_in_data.rx_byte;
        o_q_cmd.cool_on  = i_in_data.block_coolant_on;
        o_q_cmd.cool_off = i_in_data.block_coolant_off;
    end

endmodule

// ----- rtl/rcrx_queue.sv -----
// Short command queue between front and back
module rcrx_queue #(
    parameter int DEPTH = rcrx_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr_valid,
    output logic           o_wr_ready,
    input  rcrx_pkg::t_cmd i_wr_cmd,
    output logic           o_rd_valid,
    input  logic           i_rd_ready,
    output rcrx_pkg::t_cmd o_rd_cmd
);
    import rcrx_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL = CW'(DEPTH);

    t_cmd          r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;
    logic          w_push, w_pop;

    assign o_wr_ready = (r_count != FULL);
    assign o_rd_valid = (r_count != '0);
    assign o_rd_cmd   = r_mem[r_rd_ptr];
    assign w_push     = i_wr_valid && o_wr_ready;
    assign w_pop      = o_rd_valid && i_rd_ready;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) n_wr_ptr = (r_wr_ptr == LAST) ? '0 : r_wr_ptr + 1'b1;
        if (w_pop)  n_rd_ptr = (r_rd_ptr == LAST) ? '0 : r_rd_ptr + 1'b1;
        if (w_push && !w_pop)      n_count = r_count + 1'b1;
        else if (w_pop && !w_push) n_count = r_count - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wr_ptr] <= i_wr_cmd;
    end

endmodule

// ----- rtl/rcrx_back.sv -----
// Back part: executes commands, keeps state, registers the result item
`include "realtime_command_rx_front_end_core_macros.svh"

module rcrx_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [7:0]          i_cfg_wdata,
    input  logic                i_cmd_valid,
    output logic                o_cmd_ready,
    input  rcrx_pkg::t_cmd      i_cmd,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output rcrx_pkg::t_out_item o_out_data
);
    import rcrx_pkg::*;

    logic [7:0] r_capacity;
    logic       r_hold, n_hold;
    logic       r_cool, n_cool;
    logic       r_susp, n_susp;
    logic [7:0] r_unacked, n_unacked;
    logic [7:0] r_line, n_line;
    logic       r_halt, n_halt;
    logic       r_out_valid, n_out_valid;
    t_out_item  r_out, n_out;

    t_action    w_action;
    logic [7:0] w_data;
    logic [7:0] w_len;
    logic [8:0] w_next_cnt;
    logic       w_pop;

    assign o_cmd_ready = !r_out_valid || i_out_ready;
    assign w_pop       = i_cmd_valid && o_cmd_ready;
    assign w_next_cnt  = {1'b0, r_unacked} + 9'd1;

    always_comb begin
        n_hold    = r_hold;
        n_cool    = r_cool;
        n_susp    = r_susp;
        n_unacked = r_unacked;
        n_line    = r_line;
        n_halt    = r_halt;
        w_action  = ACT_NONE;
        w_data    = '0;
        w_len     = '0;
        if (i_cmd.kind == K_RESET) begin
            n_hold    = 1'b0;
            n_cool    = 1'b0;
            n_susp    = 1'b0;
            n_unacked = '0;
            n_line    = '0;
            n_halt    = 1'b0;
            w_action  = ACT_RESET;
        end else if (!r_halt) begin
            case (i_cmd.kind)
                K_STATUS: w_action = ACT_STATUS;
                K_HOLD: begin
                    n_hold   = 1'b1;
                    w_action = ACT_HOLD;
                end
                K_RESUME: begin
                    if (r_susp) begin
                        n_cool = 1'b1;
                        n_susp = 1'b0;
                    end
                    n_hold   = 1'b0;
                    w_action = ACT_RESUME;
                end
                K_JOG: w_action = ACT_JOG;
                K_TOGGLE: begin
                    // only acts while held
                    if (r_hold) begin
                        if (r_susp) begin
                            n_cool = 1'b1;
                            n_susp = 1'b0;
                        end else if (r_cool) begin
                            n_cool = 1'b0;
                            n_susp = 1'b1;
                        end
                    end
                    w_action = ACT_TOGGLE;
                end
                K_LINE_END, K_ORDINARY: begin
                    if (w_next_cnt > {1'b0, r_capacity}) begin
                        n_halt   = 1'b1;
                        w_action = ACT_OVERFLOW;
                    end else if (i_cmd.kind == K_LINE_END) begin
                        w_len     = r_line;
                        n_line    = '0;
                        n_unacked = '0;
                        w_action  = ACT_LINE_END;
                    end else begin
                        n_unacked = w_next_cnt[7:0];
                        if (r_line != LINE_COUNT_MAX) n_line = r_line + 8'd1;
                        w_data   = i_cmd.data;
                        w_action = ACT_STORED;
                    end
                end
                K_BLOCK: begin
                    if (i_cmd.cool_on)  n_cool = 1'b1;
                    if (i_cmd.cool_off) n_cool = 1'b0;
                end
                default: w_action = ACT_NONE;
            endcase
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (w_pop) begin
            n_out_valid             = 1'b1;
            n_out.action            = w_action;
            n_out.data_byte         = w_data;
            n_out.line_length       = w_len;
            n_out.hold_active       = n_hold;
            n_out.coolant_on        = n_cool;
            n_out.coolant_suspended = n_susp;
            n_out.unacked_bytes     = n_unacked;
            n_out.halted            = n_halt;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity  <= CAPACITY_RESET;
            r_hold      <= 1'b0;
            r_cool      <= 1'b0;
            r_susp      <= 1'b0;
            r_unacked   <= '0;
            r_line      <= '0;
            r_halt      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) r_capacity <= i_cfg_wdata;
            if (w_pop) begin
                r_hold    <= n_hold;
                r_cool    <= n_cool;
                r_susp    <= n_susp;
                r_unacked <= n_unacked;
                r_line    <= n_line;
                r_halt    <= n_halt;
            end
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `RCRX_ASSERT_IMP(a_ovf_halts, i_clk, i_rst_n, r_out_valid && r_out.action == ACT_OVERFLOW, r_out.halted && r_halt)
    `RCRX_ASSERT_NXT(a_halt_silent, i_clk, i_rst_n, w_pop && r_halt && i_cmd.kind != K_RESET, r_out.action == ACT_NONE && r_halt)
    `RCRX_ASSERT_NXT(a_reset_clears, i_clk, i_rst_n, w_pop && i_cmd.kind == K_RESET, !r_halt && r_unacked == '0 && r_line == '0 && !r_hold)
    `RCRX_ASSERT_IMP(a_line_end_clear, i_clk, i_rst_n, r_out_valid && r_out.action == ACT_LINE_END, r_out.unacked_bytes == '0 && !r_out.halted)

endmodule

// ----- rtl/realtime_command_rx_front_end_core.sv -----
// Top level of the realtime command receive front end
//
// channel  | signals                          | direction
// input    | i_in_valid/o_in_ready/i_in_data  | byte or block-finished item in
// result   | o_out_valid/i_out_ready/o_out_data | one result item per input item
// config   | i_cfg_we/i_cfg_wdata             | rx capacity write, no wait
//
// Sustains one item per cycle while i_out_ready stays high. An accepted item
// enters the command queue; the back part takes it from the queue and loads
// the result register, which drives o_out_valid.
// The input stalls only when the command queue is full; the queue fills while
// the result register is held by a low i_out_ready.
// Synchronous reset clears all flags and counters and sets capacity to 127.
module realtime_command_rx_front_end_core #(
    parameter int QUEUE_DEPTH = rcrx_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  rcrx_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output rcrx_pkg::t_out_item o_out_data,
    input  logic                i_cfg_we,
    input  logic [7:0]          i_cfg_wdata
);
    import rcrx_pkg::*;

    logic w_wr_valid, w_wr_ready;
    logic w_rd_valid, w_rd_ready;
    t_cmd w_wr_cmd, w_rd_cmd;

    rcrx_front u_front (
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .i_q_ready  (w_wr_ready),
        .o_q_valid  (w_wr_valid),
        .o_q_cmd    (w_wr_cmd)
    );

    rcrx_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (w_wr_valid),
        .o_wr_ready (w_wr_ready),
        .i_wr_cmd   (w_wr_cmd),
        .o_rd_valid (w_rd_valid),
        .i_rd_ready (w_rd_ready),
        .o_rd_cmd   (w_rd_cmd)
    );

    rcrx_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd_valid (w_rd_valid),
        .o_cmd_ready (w_rd_ready),
        .i_cmd       (w_rd_cmd),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule
